@@ hw/rtl/hodom_pkg.sv @@
// Shared widths, constants, motion class codes and the CORDIC angle table.
package hodom_pkg;

	// Field widths
	localparam int VEL_W    = 16;
	localparam int WHEEL_W  = 18;
	localparam int POS_W    = 32;
	localparam int HEAD_W   = 16;
	localparam int DIST_W   = 32;
	localparam int CLASS_W  = 3;
	localparam int OFFSET_W = 16;

	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd128;

	// CORDIC iteration count default and angle table size
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_COUNT       = 24;
	localparam int ATAN_IDX_W       = 5;

	// Heading wrap limits, Q4.12, at 18 bits
	localparam logic signed [17:0] PI_Q12     = 18'sd12868;
	localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

	// Quarter turn in Q16 and inverse CORDIC gain in Q16
	localparam logic signed [19:0] HALF_PI_Q16  = 20'sd102944;
	localparam logic signed [16:0] INV_GAIN_Q16 = 17'sd39797;

	// Motion class codes
	localparam logic [CLASS_W-1:0] MC_STILL  = 3'd0;
	localparam logic [CLASS_W-1:0] MC_FWD    = 3'd1;
	localparam logic [CLASS_W-1:0] MC_BACK   = 3'd2;
	localparam logic [CLASS_W-1:0] MC_LEFT   = 3'd3;
	localparam logic [CLASS_W-1:0] MC_RIGHT  = 3'd4;
	localparam logic [CLASS_W-1:0] MC_TURN_L = 3'd5;
	localparam logic [CLASS_W-1:0] MC_TURN_R = 3'd6;

	// atan(2^-i) in Q16, rounded
	function automatic logic [16:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic [16:0] a;
		unique case (idx)
			5'd0:    a = 17'd51472;
			5'd1:    a = 17'd30386;
			5'd2:    a = 17'd16055;
			5'd3:    a = 17'd8150;
			5'd4:    a = 17'd4091;
			5'd5:    a = 17'd2047;
			5'd6:    a = 17'd1024;
			5'd7:    a = 17'd512;
			5'd8:    a = 17'd256;
			5'd9:    a = 17'd128;
			5'd10:   a = 17'd64;
			5'd11:   a = 17'd32;
			5'd12:   a = 17'd16;
			5'd13:   a = 17'd8;
			5'd14:   a = 17'd4;
			5'd15:   a = 17'd2;
			5'd16:   a = 17'd1;
			default: a = 17'd0;
		endcase
		return a;
	endfunction

endpackage

@@ hw/rtl/hodom_if.sv @@
// Valid/ready channel interfaces for velocity commands and odometry results.
interface hodom_cmd_if;
	import hodom_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] vx;
	logic signed [VEL_W-1:0] vy;
	logic signed [VEL_W-1:0] omega;

	modport source (output valid, output vx, output vy, output omega, input ready);
	modport sink   (input valid, input vx, input vy, input omega, output ready);
endinterface

interface hodom_res_if;
	import hodom_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [WHEEL_W-1:0] front_left;
	logic signed [WHEEL_W-1:0] front_right;
	logic signed [WHEEL_W-1:0] back_left;
	logic signed [WHEEL_W-1:0] back_right;
	logic signed [POS_W-1:0]   pos_x;
	logic signed [POS_W-1:0]   pos_y;
	logic signed [HEAD_W-1:0]  heading_out;
	logic        [DIST_W-1:0]  distance_out;
	logic        [CLASS_W-1:0] motion_class;

	modport source (
		output valid, output front_left, output front_right, output back_left,
		output back_right, output pos_x, output pos_y, output heading_out,
		output distance_out, output motion_class, input ready
	);
	modport sink (
		input valid, input front_left, input front_right, input back_left,
		input back_right, input pos_x, input pos_y, input heading_out,
		input distance_out, input motion_class, output ready
	);
endinterface

@@ hw/rtl/holonomic_odometry_and_wheel_mix.sv @@
// Omni wheel mixer and odometry integrator on one shared CORDIC stage and multiplier.
//
//   channel   dir  handshake      content
//   cmd       in   valid/ready    vx, vy (Q8.8), omega (Q4.12)
//   res       out  valid/ready    four wheel speeds, pos_x/pos_y, heading, distance, class
//   cfg_wr_*  in   write enable   wheel_offset (Q8.8)
//
// One item occupies the block until its result is loaded: one
// shift/add stage runs the rotation, then the magnitude vectoring, and one
// multiplier removes the gain and forms omega times the offset.
// cmd.ready is high only while idle. A finished result sits in the output
// register; the last step waits while that register is full and res.ready is low.
// Reset clears position, heading, distance and sets the offset to 0.5.
module holonomic_odometry_and_wheel_mix #(
	parameter int CORDIC_STEPS = hodom_pkg::CORDIC_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hodom_cmd_if.sink                      cmd,
	hodom_res_if.source                    res,
	input  logic                           cfg_wr_en,
	input  logic [hodom_pkg::OFFSET_W-1:0] cfg_wr_data
);
	import hodom_pkg::*;

	localparam int CNT_W = $clog2(CORDIC_STEPS);
	localparam int DP_W  = 36;
	localparam int PR_W  = DP_W + 17;
	localparam logic signed [PR_W-1:0] RND_HALF = 53'sd2147483648;

	// Sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ROT  = 4'd1;
	localparam logic [3:0] S_MX   = 4'd2;
	localparam logic [3:0] S_MY   = 4'd3;
	localparam logic [3:0] S_MT   = 4'd4;
	localparam logic [3:0] S_VL   = 4'd5;
	localparam logic [3:0] S_VEC  = 4'd6;
	localparam logic [3:0] S_MM   = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	logic signed [POS_W-1:0]  pos_x_q;
	logic signed [POS_W-1:0]  pos_y_q;
	logic signed [HEAD_W-1:0] heading_q;
	logic        [DIST_W-1:0] travelled_q;
	logic [OFFSET_W-1:0]      offset_q;

	logic signed [VEL_W-1:0] vx_q;
	logic signed [VEL_W-1:0] vy_q;
	logic signed [VEL_W-1:0] om_q;
	logic signed [DP_W-1:0]  x_q;
	logic signed [DP_W-1:0]  y_q;
	logic signed [19:0]      z_q;
	logic signed [PR_W-1:0]  prod_q;
	logic signed [20:0]      t_q;

	logic signed [WHEEL_W-1:0] fl_q, fr_q, bl_q, br_q;
	logic signed [POS_W-1:0]   px_out_q, py_out_q;
	logic signed [HEAD_W-1:0]  head_out_q;
	logic        [DIST_W-1:0]  dist_out_q;
	logic        [CLASS_W-1:0] class_q;

	function automatic logic signed [WHEEL_W-1:0] sat_wheel(input logic signed [22:0] v);
		logic signed [WHEEL_W-1:0] r;
		if (v > 23'sd131071)
			r = 18'sh1FFFF;
		else if (v < -23'sd131072)
			r = 18'sh20000;
		else
			r = v[WHEEL_W-1:0];
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
		logic signed [POS_W-1:0] r;
		if (v[POS_W] != v[POS_W-1])
			r = v[POS_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	function automatic logic signed [17:0] wrap_step(input logic signed [17:0] h);
		logic signed [17:0] r;
		if (h >= PI_Q12)
			r = h - TWO_PI_Q12;
		else if (h < -PI_Q12)
			r = h + TWO_PI_Q12;
		else
			r = h;
		return r;
	endfunction

	// Rotation start vector with the quarter-turn pre-rotation
	logic signed [19:0]     z0;
	logic signed [DP_W-1:0] cvx, cvy, rx0, ry0;
	logic signed [19:0]     rz0;

	always_comb begin
		z0  = {heading_q, 4'b0000};
		cvx = {{4{cmd.vx[VEL_W-1]}}, cmd.vx, 16'b0};
		cvy = {{4{cmd.vy[VEL_W-1]}}, cmd.vy, 16'b0};
		if (z0 > HALF_PI_Q16) begin
			rx0 = -cvy;
			ry0 = cvx;
			rz0 = z0 - HALF_PI_Q16;
		end else if (z0 < -HALF_PI_Q16) begin
			rx0 = cvy;
			ry0 = -cvx;
			rz0 = z0 + HALF_PI_Q16;
		end else begin
			rx0 = cvx;
			ry0 = cvy;
			rz0 = z0;
		end
	end

	// Vectoring start vector: |vx|, vy
	logic signed [DP_W-1:0] qvx, qvy, vx0;

	always_comb begin
		qvx = {{4{vx_q[VEL_W-1]}}, vx_q, 16'b0};
		qvy = {{4{vy_q[VEL_W-1]}}, vy_q, 16'b0};
		vx0 = vx_q[VEL_W-1] ? -qvx : qvx;
	end

	// Shared CORDIC micro-rotation
	logic signed [DP_W-1:0] xs, ys, x_nx, y_nx;
	logic signed [19:0]     z_nx, atan_v;
	logic                   ccw;

	always_comb begin
		xs     = x_q >>> cnt_q;
		ys     = y_q >>> cnt_q;
		atan_v = signed'({3'b000, atan_q16(ATAN_IDX_W'(cnt_q))});
		ccw    = (state_q == S_ROT) ? !z_q[19] : y_q[DP_W-1];
		if (ccw) begin
			x_nx = x_q - ys;
			y_nx = y_q + xs;
			z_nx = z_q - atan_v;
		end else begin
			x_nx = x_q + ys;
			y_nx = y_q - xs;
			z_nx = z_q + atan_v;
		end
	end

	// Shared multiplier operand select
	logic signed [DP_W-1:0] mul_a;
	logic signed [16:0]     mul_b;

	always_comb begin
		case (state_q)
			S_MY: begin
				mul_a = y_q;
				mul_b = INV_GAIN_Q16;
			end
			S_MT: begin
				mul_a = DP_W'(om_q);
				mul_b = signed'({1'b0, offset_q});
			end
			default: begin
				mul_a = x_q;
				mul_b = INV_GAIN_Q16;
			end
		endcase
	end

	// Gain removal with round to nearest, then the accumulations
	logic signed [PR_W-1:0] rnd_sum;
	logic signed [20:0]     unscaled;
	logic signed [POS_W:0]  px_sum, py_sum;
	logic        [19:0]     d_pos;
	logic        [DIST_W:0] dist_sum;
	logic        [DIST_W-1:0] dist_nx;

	always_comb begin
		rnd_sum  = prod_q + RND_HALF;
		unscaled = rnd_sum[PR_W-1:32];
		px_sum   = (POS_W+1)'(pos_x_q) + (POS_W+1)'(unscaled);
		py_sum   = (POS_W+1)'(pos_y_q) + (POS_W+1)'(unscaled);
		d_pos    = unscaled[20] ? 20'd0 : unscaled[19:0];
		dist_sum = {1'b0, travelled_q} + (DIST_W+1)'(d_pos);
		dist_nx  = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
	end

	// Wheel mix, heading wrap and motion class
	logic signed [22:0]       wfl, wfr, wbl, wbr;
	logic signed [17:0]       h_sum, h_wr;
	logic signed [HEAD_W-1:0] head_nx;
	logic        [CLASS_W-1:0] mc;

	always_comb begin
		wfl     = 23'(vx_q) - 23'(vy_q) - 23'(t_q);
		wfr     = 23'(vx_q) + 23'(vy_q) + 23'(t_q);
		wbl     = 23'(vx_q) + 23'(vy_q) - 23'(t_q);
		wbr     = 23'(vx_q) - 23'(vy_q) + 23'(t_q);
		h_sum   = 18'(heading_q) + 18'(om_q);
		h_wr    = wrap_step(wrap_step(h_sum));
		head_nx = h_wr[HEAD_W-1:0];
		if (vx_q > 0)
			mc = MC_FWD;
		else if (vx_q < 0)
			mc = MC_BACK;
		else if (vy_q > 0)
			mc = MC_LEFT;
		else if (vy_q < 0)
			mc = MC_RIGHT;
		else if (om_q > 0)
			mc = MC_TURN_L;
		else if (om_q < 0)
			mc = MC_TURN_R;
		else
			mc = MC_STILL;
	end

	logic cmd_xfer, fin_load, last_iter;

	assign cmd_xfer  = cmd.valid && (state_q == S_IDLE);
	assign fin_load  = (state_q == S_FIN) && (!out_valid_q || res.ready);
	assign last_iter = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			heading_q   <= '0;
			travelled_q <= '0;
			offset_q    <= OFFSET_RESET;
		end else begin
			if (cfg_wr_en)
				offset_q <= cfg_wr_data;
			if (fin_load)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_xfer) begin
						state_q <= S_ROT;
						cnt_q   <= '0;
					end
				end
				S_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_iter) begin
						state_q <= S_MX;
						cnt_q   <= '0;
					end
				end
				S_MX: state_q <= S_MY;
				S_MY: begin
					pos_x_q <= sat_pos(px_sum);
					state_q <= S_MT;
				end
				S_MT: begin
					pos_y_q <= sat_pos(py_sum);
					state_q <= S_VL;
				end
				S_VL: state_q <= S_VEC;
				S_VEC: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_iter) begin
						state_q <= S_MM;
						cnt_q   <= '0;
					end
				end
				S_MM: state_q <= S_FIN;
				S_FIN: begin
					if (fin_load) begin
						travelled_q <= dist_nx;
						heading_q   <= head_nx;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd_xfer) begin
			vx_q <= cmd.vx;
			vy_q <= cmd.vy;
			om_q <= cmd.omega;
			x_q  <= rx0;
			y_q  <= ry0;
			z_q  <= rz0;
		end
		if (state_q == S_ROT || state_q == S_VEC) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
		if (state_q == S_VL) begin
			t_q <= prod_q[32:12];
			x_q <= vx0;
			y_q <= qvy;
		end
		if (fin_load) begin
			fl_q       <= sat_wheel(wfl);
			fr_q       <= sat_wheel(wfr);
			bl_q       <= sat_wheel(wbl);
			br_q       <= sat_wheel(wbr);
			px_out_q   <= pos_x_q;
			py_out_q   <= pos_y_q;
			head_out_q <= head_nx;
			dist_out_q <= dist_nx;
			class_q    <= mc;
		end
	end

	assign cmd.ready        = (state_q == S_IDLE);
	assign res.valid        = out_valid_q;
	assign res.front_left   = fl_q;
	assign res.front_right  = fr_q;
	assign res.back_left    = bl_q;
	assign res.back_right   = br_q;
	assign res.pos_x        = px_out_q;
	assign res.pos_y        = py_out_q;
	assign res.heading_out  = head_out_q;
	assign res.distance_out = dist_out_q;
	assign res.motion_class = class_q;

	// Heading only moves when a result is loaded
	a_heading_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_FIN) |=> $stable(heading_q))
		else $error("heading changed outside the final step");

	// A new result appears only out of the final step
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> ($past(state_q) == S_FIN))
		else $error("result valid raised outside the final step");

	// Travelled distance never decreases
	a_dist_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (travelled_q >= $past(travelled_q)))
		else $error("travelled distance decreased");

endmodule
